@@ rtl/core/plk_pkg.sv @@
// plk_pkg: shared types, constants and helper functions of the plasma lens field kick core
// no dependencies; imported by every module under rtl/core
package plk_pkg;

   localparam int MAX_NODES   = 16;
   localparam int NODE_W      = $clog2(MAX_NODES);
   localparam int NODE_CNT_W  = 5;
   localparam int FRAC_BITS   = 16;
   localparam int COEF_BITS   = 30;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 32;
   localparam int MULW_STAGES = 6;
   localparam int SQRT_STAGES = 32;
   localparam int DIV_STAGES  = COEF_BITS + 1;
   localparam int POLY_TERMS  = 6;

   localparam logic OP_LOAD     = 1'b0;
   localparam logic OP_PARTICLE = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GEOMETRY_MODE = 2'd0,
      CSR_NODE_COUNT    = 2'd1,
      CSR_RADIUS_SCALE  = 2'd2,
      CSR_FIELD_SCALE   = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      GEOM_OFF      = 2'd0,
      GEOM_PLANAR   = 2'd1,
      GEOM_CYL      = 2'd2,
      GEOM_RESERVED = 2'd3
   } geom_type;

   // polynomial coefficients over 0.106493, signed Q30
   localparam logic [63:0] QC_0 = ((64'd157750 << COEF_BITS) + 64'd106493 / 2) / 64'd106493;
   localparam logic [63:0] QC_1 = ((64'd233967 << COEF_BITS) + 64'd3194790 / 2) / 64'd3194790;
   localparam logic [63:0] QC_2 = ((64'd786747 << COEF_BITS) + 64'd4259720 / 2) / 64'd4259720;
   localparam logic [63:0] QC_3 = ((64'd878334 << COEF_BITS) + 64'd532465 / 2) / 64'd532465;
   localparam logic [63:0] QC_4 = ((64'd1322130 << COEF_BITS) + 64'd638958 / 2) / 64'd638958;
   localparam logic [63:0] QC_5 = ((64'd751897 << COEF_BITS) + 64'd745451 / 2) / 64'd745451;

   localparam logic signed [63:0] POLY_COEF [POLY_TERMS] = '{
      $signed(QC_0), -$signed(QC_1), $signed(QC_2),
      -$signed(QC_3), $signed(QC_4), -$signed(QC_5)
   };

   typedef struct packed {
      logic [0:0]         opcode;
      logic [3:0]         node_index;
      logic signed [31:0] node_position;
      logic signed [31:0] node_density;
      logic signed [31:0] cell_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
   } plk_req_type;

   typedef struct packed {
      logic signed [31:0] delta_b2;
      logic signed [31:0] delta_b3;
   } plk_rsp_type;

   // everything a particle carries down the pipeline
   typedef struct packed {
      logic               valid;
      logic               match;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic [63:0]        rad;
      logic [63:0]        sq_z;
      logic [33:0]        sq_rem;
      logic [31:0]        root;
      logic [31:0]        radius;
      logic [32:0]        span;
      logic [33:0]        rem_t;
      logic [33:0]        rem_c;
      logic [33:0]        rem_s;
      logic [30:0]        q_t;
      logic [30:0]        q_c;
      logic [30:0]        q_s;
      logic signed [31:0] dens_base;
      logic signed [32:0] dens_delta;
      logic signed [63:0] dens_prod;
      logic [63:0]        xi_prod;
      logic signed [35:0] ne;
      logic [48:0]        xi;
      logic signed [63:0] poly;
   } plk_ctx_type;

   function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
      logic signed [64:0] sum;
      sum = 65'(a) + 65'(b);
      if (sum[64] != sum[63]) begin
         sat_add64 = sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end else begin
         sat_add64 = sum[63:0];
      end
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) begin
         sat32 = 32'sh7fffffff;
      end else if (v < -64'sd2147483648) begin
         sat32 = 32'sh80000000;
      end else begin
         sat32 = v[31:0];
      end
   endfunction

endpackage

@@ rtl/core/plk_front.sv @@
// plk_front: density profile store, segment search and squared radius (three stages)
// depends on plk_pkg
module plk_front
   import plk_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  enable,
   input  logic                  accept,
   input  plk_req_type           req_payload,
   input  logic [NODE_CNT_W-1:0] node_count,
   output plk_ctx_type           ctx_out
);

   logic signed [31:0] pos_ff  [MAX_NODES];
   logic signed [31:0] dens_ff [MAX_NODES];

   logic [NODE_CNT_W-1:0] n_eff;
   logic                  found;
   logic signed [31:0]    p0_in, p1_in, d0_in, d1_in;

   logic               a_valid_ff, a_match_ff;
   logic signed [31:0] a_x_ff, a_p0_ff, a_p1_ff, a_d0_ff, a_d1_ff, a_y_ff, a_z_ff;

   logic signed [63:0] y_w, z_w;
   plk_ctx_type        b_in, b_ff, c_in, c_ff;

   always_ff @(posedge clock) begin
      if (accept && req_payload.opcode == OP_LOAD) begin
         pos_ff[req_payload.node_index]  <= req_payload.node_position;
         dens_ff[req_payload.node_index] <= req_payload.node_density;
      end
   end

   assign n_eff = (node_count > NODE_CNT_W'(MAX_NODES)) ? NODE_CNT_W'(MAX_NODES) : node_count;

   // first segment holding cell_x wins
   always_comb begin
      found = 1'b0;
      p0_in = '0;
      p1_in = '0;
      d0_in = '0;
      d1_in = '0;
      for (int l = 0; l < MAX_NODES - 1; l++) begin
         if (!found && (NODE_CNT_W'(l + 1) < n_eff) && (req_payload.cell_x >= pos_ff[l])
             && (req_payload.cell_x < pos_ff[l + 1])) begin
            found = 1'b1;
            p0_in = pos_ff[l];
            p1_in = pos_ff[l + 1];
            d0_in = dens_ff[l];
            d1_in = dens_ff[l + 1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (enable) begin
         a_valid_ff <= accept && (req_payload.opcode == OP_PARTICLE);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         a_match_ff <= found;
         a_x_ff     <= req_payload.cell_x;
         a_p0_ff    <= p0_in;
         a_p1_ff    <= p1_in;
         a_d0_ff    <= d0_in;
         a_d1_ff    <= d1_in;
         a_y_ff     <= req_payload.pos_y;
         a_z_ff     <= req_payload.pos_z;
      end
   end

   assign y_w = 64'(a_y_ff);
   assign z_w = 64'(a_z_ff);

   always_comb begin
      b_in            = '0;
      b_in.valid      = a_valid_ff;
      b_in.match      = a_match_ff;
      b_in.pos_y      = a_y_ff;
      b_in.pos_z      = a_z_ff;
      b_in.rem_t      = 34'(a_x_ff) - 34'(a_p0_ff);
      b_in.span       = 33'(a_p1_ff) - 33'(a_p0_ff);
      b_in.dens_base  = a_d0_ff;
      b_in.dens_delta = 33'(a_d1_ff) - 33'(a_d0_ff);
      b_in.rad        = y_w * y_w;
      b_in.sq_z       = z_w * z_w;
   end

   always_comb begin
      c_in        = b_ff;
      c_in.rad    = b_ff.rad + b_ff.sq_z;
      c_in.sq_rem = '0;
      c_in.root   = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_ff.valid <= 1'b0;
         c_ff.valid <= 1'b0;
      end else if (enable) begin
         b_ff <= b_in;
         c_ff <= c_in;
      end
   end

   assign ctx_out = c_ff;

endmodule

@@ rtl/core/plk_sqrt.sv @@
// plk_sqrt: pipelined integer square root of the squared radius, one root bit per stage
// depends on plk_pkg
module plk_sqrt
   import plk_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        enable,
   input  plk_ctx_type ctx_in,
   output plk_ctx_type ctx_out
);

   plk_ctx_type stg_ff [SQRT_STAGES];

   for (genvar i = 0; i < SQRT_STAGES; i++) begin : g_step
      plk_ctx_type cur;
      plk_ctx_type nxt;
      logic [35:0] rem_sh;
      logic [35:0] trial;
      logic        ge;

      if (i == 0) begin : g_first
         assign cur = ctx_in;
      end else begin : g_next
         assign cur = stg_ff[i-1];
      end

      assign rem_sh = {cur.sq_rem, cur.rad[63:62]};
      assign trial  = {2'b00, cur.root, 2'b01};
      assign ge     = rem_sh >= trial;

      always_comb begin
         nxt        = cur;
         nxt.rad    = {cur.rad[61:0], 2'b00};
         nxt.sq_rem = ge ? 34'(rem_sh - trial) : rem_sh[33:0];
         nxt.root   = {cur.root[30:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            stg_ff[i].valid <= 1'b0;
         end else if (enable) begin
            stg_ff[i] <= nxt;
         end
      end
   end

   assign ctx_out = stg_ff[SQRT_STAGES-1];

endmodule

@@ rtl/core/plk_div.sv @@
// plk_div: three restoring dividers side by side, one quotient bit per stage
// (segment fraction, cosine and sine); depends on plk_pkg
module plk_div
   import plk_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        enable,
   input  plk_ctx_type ctx_in,
   output plk_ctx_type ctx_out
);

   plk_ctx_type stg_ff [DIV_STAGES];

   for (genvar i = 0; i < DIV_STAGES; i++) begin : g_step
      plk_ctx_type cur;
      plk_ctx_type nxt;
      logic [33:0] dif_t, dif_c, dif_s;
      logic        ge_t, ge_c, ge_s;

      if (i == 0) begin : g_first
         assign cur = ctx_in;
      end else begin : g_next
         assign cur = stg_ff[i-1];
      end

      assign ge_t  = cur.rem_t >= {1'b0, cur.span};
      assign ge_c  = cur.rem_c >= {2'b00, cur.radius};
      assign ge_s  = cur.rem_s >= {2'b00, cur.radius};
      assign dif_t = cur.rem_t - {1'b0, cur.span};
      assign dif_c = cur.rem_c - {2'b00, cur.radius};
      assign dif_s = cur.rem_s - {2'b00, cur.radius};

      always_comb begin
         nxt       = cur;
         nxt.rem_t = ge_t ? {dif_t[32:0], 1'b0} : {cur.rem_t[32:0], 1'b0};
         nxt.rem_c = ge_c ? {dif_c[32:0], 1'b0} : {cur.rem_c[32:0], 1'b0};
         nxt.rem_s = ge_s ? {dif_s[32:0], 1'b0} : {cur.rem_s[32:0], 1'b0};
         nxt.q_t   = {cur.q_t[29:0], ge_t};
         nxt.q_c   = {cur.q_c[29:0], ge_c};
         nxt.q_s   = {cur.q_s[29:0], ge_s};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            stg_ff[i].valid <= 1'b0;
         end else if (enable) begin
            stg_ff[i] <= nxt;
         end
      end
   end

   assign ctx_out = stg_ff[DIV_STAGES-1];

endmodule

@@ rtl/core/plk_mulw.sv @@
// plk_mulw: 64x64 signed multiply, rounded half away from zero, shifted by 16 or 30,
// saturated to 64 bit; six stages, partial products of 32x32; depends on plk_pkg
module plk_mulw
   import plk_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               enable,
   input  plk_ctx_type        ctx_in,
   input  logic signed [63:0] op_a,
   input  logic signed [63:0] op_b,
   input  logic               use_coef_shift,
   output plk_ctx_type        ctx_out,
   output logic signed [63:0] product
);

   plk_ctx_type ctx_ff [MULW_STAGES];
   logic        neg_ff [MULW_STAGES-1];
   logic        sel_ff [MULW_STAGES-2];

   logic [63:0]  a_u, b_u, mag_a_in, mag_b_in;
   logic [63:0]  mag_a_ff, mag_b_ff;
   logic [63:0]  ll_ff, lh_ff, ll3_ff, lh3_ff, hl_ff, hh_ff;
   logic [31:0]  a_hi_ff, b_lo_ff, b_hi_ff;
   logic [127:0] full_in, full_ff, half, rnd, shifted;
   logic [62:0]  mag_in, mag_ff;
   logic [63:0]  prod_u;
   logic signed [63:0] product_ff;

   assign a_u      = op_a;
   assign b_u      = op_b;
   assign mag_a_in = op_a[63] ? (~a_u + 64'd1) : a_u;
   assign mag_b_in = op_b[63] ? (~b_u + 64'd1) : b_u;

   assign full_in = {64'd0, ll3_ff} + ({64'd0, lh3_ff} << 32) + ({64'd0, hl_ff} << 32)
                    + {hh_ff, 64'd0};

   assign half    = sel_ff[MULW_STAGES-3] ? (128'd1 << (COEF_BITS - 1))
                                          : (128'd1 << (FRAC_BITS - 1));
   assign rnd     = full_ff + half;
   assign shifted = sel_ff[MULW_STAGES-3] ? (rnd >> COEF_BITS) : (rnd >> FRAC_BITS);
   assign mag_in  = (|shifted[127:63]) ? {63{1'b1}} : shifted[62:0];
   assign prod_u  = {1'b0, mag_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MULW_STAGES; i++) begin
            ctx_ff[i].valid <= 1'b0;
         end
      end else if (enable) begin
         ctx_ff[0] <= ctx_in;
         for (int i = 1; i < MULW_STAGES; i++) begin
            ctx_ff[i] <= ctx_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         neg_ff[0] <= op_a[63] ^ op_b[63];
         for (int i = 1; i < MULW_STAGES - 1; i++) begin
            neg_ff[i] <= neg_ff[i-1];
         end
         sel_ff[0] <= use_coef_shift;
         for (int i = 1; i < MULW_STAGES - 2; i++) begin
            sel_ff[i] <= sel_ff[i-1];
         end
         mag_a_ff   <= mag_a_in;
         mag_b_ff   <= mag_b_in;
         ll_ff      <= mag_a_ff[31:0] * mag_b_ff[31:0];
         lh_ff      <= mag_a_ff[31:0] * mag_b_ff[63:32];
         a_hi_ff    <= mag_a_ff[63:32];
         b_lo_ff    <= mag_b_ff[31:0];
         b_hi_ff    <= mag_b_ff[63:32];
         hl_ff      <= a_hi_ff * b_lo_ff;
         hh_ff      <= a_hi_ff * b_hi_ff;
         ll3_ff     <= ll_ff;
         lh3_ff     <= lh_ff;
         full_ff    <= full_in;
         mag_ff     <= mag_in;
         product_ff <= neg_ff[MULW_STAGES-2] ? (~prod_u + 64'd1) : prod_u;
      end
   end

   assign ctx_out = ctx_ff[MULW_STAGES-1];
   assign product = product_ff;

endmodule

@@ rtl/core/plasma_lens_field_kick_core.sv @@
// plasma_lens_field_kick_core: top level of the plasma lens field kick pipeline
// depends on plk_pkg, plk_front, plk_sqrt, plk_div, plk_mulw
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  plk_req_type (load node or particle)
//   rsp      out        rsp_valid / rsp_stall  plk_rsp_type (one per particle)
//   csr      in         csr_write_enable       csr_index, csr_write_data
//
// one transaction per cycle in while req_stall is low; a particle result passes through the
// front, square root, radius, divide, density, polynomial, scale and projection stages and
// the output register; load transactions give no result
// reset is synchronous and clears all valid bits and the configuration registers
// a stalled result freezes the whole pipeline and req_stall follows it in the same cycle
module plasma_lens_field_kick_core
   import plk_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  plk_req_type           req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output plk_rsp_type           rsp_payload,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   geom_type              geom_ff;
   logic [NODE_CNT_W-1:0] node_count_ff;
   logic [31:0]           radius_scale_ff;
   logic signed [31:0]    field_scale_ff;

   logic        enable, accept;
   logic        rsp_valid_ff;
   plk_rsp_type rsp_payload_ff;

   plk_ctx_type front_ctx, sqrt_ctx, r_in, r_ff, div_ctx, n1_in, n1_ff, n2_in, n2_ff;
   logic [31:0] abs_y, abs_z;
   logic signed [31:0] t_s;
   logic signed [63:0] ne_full;

   plk_ctx_type        poly_ctx [POLY_TERMS];
   plk_ctx_type        last_ctx, field_ctx, b_ctx, cos_ctx;
   logic signed [63:0] last_prod, field_prod, b_prod, cos_prod, sin_prod;
   logic [63:0]        qc_u, qs_u, cos_op, sin_op;
   logic               zero_out;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         geom_ff         <= GEOM_OFF;
         node_count_ff   <= '0;
         radius_scale_ff <= 32'd65536;
         field_scale_ff  <= 32'sd65536;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_GEOMETRY_MODE: geom_ff         <= geom_type'(csr_write_data[1:0]);
            CSR_NODE_COUNT:    node_count_ff   <= csr_write_data[NODE_CNT_W-1:0];
            CSR_RADIUS_SCALE:  radius_scale_ff <= csr_write_data;
            CSR_FIELD_SCALE:   field_scale_ff  <= csr_write_data;
         endcase
      end
   end

   assign enable    = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !enable;
   assign accept    = req_valid && enable;

   plk_front u_front (
      .clock       (clock),
      .reset       (reset),
      .enable      (enable),
      .accept      (accept),
      .req_payload (req_payload),
      .node_count  (node_count_ff),
      .ctx_out     (front_ctx)
   );

   plk_sqrt u_sqrt (
      .clock   (clock),
      .reset   (reset),
      .enable  (enable),
      .ctx_in  (front_ctx),
      .ctx_out (sqrt_ctx)
   );

   // radius and divider setup
   assign abs_y = sqrt_ctx.pos_y[31] ? (~sqrt_ctx.pos_y + 32'd1) : sqrt_ctx.pos_y;
   assign abs_z = sqrt_ctx.pos_z[31] ? (~sqrt_ctx.pos_z + 32'd1) : sqrt_ctx.pos_z;

   always_comb begin
      r_in        = sqrt_ctx;
      r_in.radius = (geom_ff == GEOM_PLANAR) ? abs_y : sqrt_ctx.root;
      r_in.rem_c  = {2'b00, abs_y};
      r_in.rem_s  = {2'b00, abs_z};
      r_in.q_t    = '0;
      r_in.q_c    = '0;
      r_in.q_s    = '0;
   end

   plk_div u_div (
      .clock   (clock),
      .reset   (reset),
      .enable  (enable),
      .ctx_in  (r_ff),
      .ctx_out (div_ctx)
   );

   // density interpolation and xi
   assign t_s = {1'b0, div_ctx.q_t};

   always_comb begin
      n1_in           = div_ctx;
      n1_in.dens_prod = div_ctx.dens_delta * t_s;
      n1_in.xi_prod   = div_ctx.radius * radius_scale_ff;
   end

   assign ne_full = 64'(n1_ff.dens_base)
                    + ((n1_ff.dens_prod + (64'sd1 <<< (COEF_BITS - 1))) >>> COEF_BITS);

   always_comb begin
      n2_in      = n1_ff;
      n2_in.ne   = n1_ff.match ? ne_full[35:0] : (36'sd1 <<< FRAC_BITS);
      n2_in.xi   = 49'((n1_ff.xi_prod + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS);
      n2_in.poly = POLY_COEF[POLY_TERMS-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r_ff.valid  <= 1'b0;
         n1_ff.valid <= 1'b0;
         n2_ff.valid <= 1'b0;
      end else if (enable) begin
         r_ff  <= r_in;
         n1_ff <= n1_in;
         n2_ff <= n2_in;
      end
   end

   assign poly_ctx[0] = n2_ff;

   // horner steps: p = sat(sat(p * xi) + c), highest coefficient first
   for (genvar k = 0; k < POLY_TERMS - 1; k++) begin : g_poly
      plk_ctx_type        mul_ctx;
      plk_ctx_type        add_in;
      plk_ctx_type        add_ff;
      logic signed [63:0] mul_prod;

      plk_mulw u_mul (
         .clock          (clock),
         .reset          (reset),
         .enable         (enable),
         .ctx_in         (poly_ctx[k]),
         .op_a           (poly_ctx[k].poly),
         .op_b           ({15'd0, poly_ctx[k].xi}),
         .use_coef_shift (1'b0),
         .ctx_out        (mul_ctx),
         .product        (mul_prod)
      );

      always_comb begin
         add_in      = mul_ctx;
         add_in.poly = sat_add64(mul_prod, POLY_COEF[POLY_TERMS-2-k]);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            add_ff.valid <= 1'b0;
         end else if (enable) begin
            add_ff <= add_in;
         end
      end

      assign poly_ctx[k+1] = add_ff;
   end

   plk_mulw u_mul_last (
      .clock          (clock),
      .reset          (reset),
      .enable         (enable),
      .ctx_in         (poly_ctx[POLY_TERMS-1]),
      .op_a           (poly_ctx[POLY_TERMS-1].poly),
      .op_b           ({15'd0, poly_ctx[POLY_TERMS-1].xi}),
      .use_coef_shift (1'b0),
      .ctx_out        (last_ctx),
      .product        (last_prod)
   );

   plk_mulw u_mul_field (
      .clock          (clock),
      .reset          (reset),
      .enable         (enable),
      .ctx_in         (last_ctx),
      .op_a           (last_prod),
      .op_b           (64'(field_scale_ff)),
      .use_coef_shift (1'b1),
      .ctx_out        (field_ctx),
      .product        (field_prod)
   );

   plk_mulw u_mul_dens (
      .clock          (clock),
      .reset          (reset),
      .enable         (enable),
      .ctx_in         (field_ctx),
      .op_a           (field_prod),
      .op_b           (64'(field_ctx.ne)),
      .use_coef_shift (1'b0),
      .ctx_out        (b_ctx),
      .product        (b_prod)
   );

   // projection factors in Q30; planar uses a unit factor carrying the sign of y
   assign qc_u = {33'd0, b_ctx.q_c};
   assign qs_u = {33'd0, b_ctx.q_s};

   always_comb begin
      if (geom_ff == GEOM_CYL) begin
         cos_op = b_ctx.pos_y[31] ? (~qc_u + 64'd1) : qc_u;
         sin_op = b_ctx.pos_z[31] ? (~qs_u + 64'd1) : qs_u;
      end else begin
         cos_op = '0;
         sin_op = (b_ctx.pos_y > 32'sd0) ? (64'd1 << COEF_BITS) : (~(64'd1 << COEF_BITS) + 64'd1);
      end
   end

   plk_mulw u_mul_cos (
      .clock          (clock),
      .reset          (reset),
      .enable         (enable),
      .ctx_in         (b_ctx),
      .op_a           (b_prod),
      .op_b           (cos_op),
      .use_coef_shift (1'b1),
      .ctx_out        (cos_ctx),
      .product        (cos_prod)
   );

   plk_mulw u_mul_sin (
      .clock          (clock),
      .reset          (reset),
      .enable         (enable),
      .ctx_in         (b_ctx),
      .op_a           (b_prod),
      .op_b           (sin_op),
      .use_coef_shift (1'b1),
      .ctx_out        (),
      .product        (sin_prod)
   );

   assign zero_out = ((geom_ff != GEOM_PLANAR) && (geom_ff != GEOM_CYL)) || (cos_ctx.radius == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         rsp_valid_ff <= cos_ctx.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rsp_payload_ff.delta_b2 <= zero_out ? '0 : sat32(cos_prod);
         rsp_payload_ff.delta_b3 <= zero_out ? '0 : sat32(sin_prod);
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without a stalled result");

   a_off_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && geom_ff == GEOM_OFF)
      |-> (rsp_payload.delta_b2 == '0 && rsp_payload.delta_b3 == '0))
      else $error("nonzero field increment in off mode");

   a_planar_b2: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && geom_ff == GEOM_PLANAR) |-> (rsp_payload.delta_b2 == '0))
      else $error("planar mode produced a second component");

endmodule
